// ----- hdl/wmf_pkg.sv -----
package wmf_pkg;
  localparam int PIX_W = 8;
  localparam int HW_W = 2;
  localparam int DIM_W = 11;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_WINDOW  = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_idx_t;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Border copy request handed to the result register
  typedef struct packed {
    logic             vld;
    logic             border;
    logic             last;
    logic [PIX_W-1:0] copy;
  } rank_ctl_t;
endpackage

// ----- hdl/wmf_rank_cell.sv -----
// One rank cell: compares one window element against the candidates streaming
// past and accumulates less-than and less-or-equal counts for its element.
module wmf_rank_cell #(
  parameter int CNT_W = 6
) (
  input  logic                    clk,
  input  logic                    load,
  input  logic [wmf_pkg::PIX_W-1:0] load_val,
  input  logic                    cmp_en,
  input  logic [wmf_pkg::PIX_W-1:0] cmp_val,
  output logic [wmf_pkg::PIX_W-1:0] val,
  output logic [CNT_W-1:0]        lt,
  output logic [CNT_W-1:0]        le
);
  import wmf_pkg::*;
  logic [PIX_W-1:0] val_r;
  logic [CNT_W-1:0] lt_r, le_r;

  // Load element, then count over the compare sweep
  always_ff @(posedge clk) begin
    if (load) begin
      val_r <= load_val;
      lt_r  <= '0;
      le_r  <= '0;
    end else if (cmp_en) begin
      lt_r <= lt_r + CNT_W'(cmp_val < val_r);
      le_r <= le_r + CNT_W'(cmp_val <= val_r);
    end
  end
  assign val = val_r;
  assign lt = lt_r;
  assign le = le_r;
endmodule

// ----- hdl/window_median_filter.sv -----
// Path: output k leaves with input k + hw*width + hw (drain requests push out
//   the rest); a border copy passes from brd_pend_r through the memory read
//   register into the result register, a median through the fill, wait, sweep,
//   scan and out states; the scan stops at the first cell that holds the median.
// Throughput: one request per cycle when no result is due and no result is stalled;
//   a request after a border result waits on brd_pend_r, one after a median waits
//   through fill, wait, sweep, scan and out; the rank cells and line memory set it.
// Reset (rst_n low, synchronous): positions, counters and config return to
//   defaults (hw 1, 640 x 480); line memory holds its contents.
module window_median_filter #(
  parameter int MAX_HALF_WINDOW = 3,
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] pixel_in
  input  logic                         in_tuser,   // [0] cmd
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [7:0]                   out_tdata,  // [7:0] pixel_out
  output logic                         out_tlast,  // frame_end
  input  logic                         cfg_we,
  input  logic [wmf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [wmf_pkg::DIM_W-1:0]    cfg_data
);
  import wmf_pkg::*;
  localparam int ROWS = 2 * MAX_HALF_WINDOW + 1;
  localparam int NCELL = ROWS * ROWS;
  localparam int CNT_W = $clog2(NCELL + 1);
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int HWW = $clog2(MAX_HALF_WINDOW + 1);
  localparam int PW = CW > $clog2(MAX_HEIGHT) ? CW + 1 : $clog2(MAX_HEIGHT) + 1;
  localparam int LAG_W = 2 * PW + 2;
  localparam int DEPTH = ROWS * MAX_WIDTH;
  localparam int AW = $clog2(DEPTH);
  localparam int IW = $clog2(NCELL);

  typedef enum logic [2:0] {ST_RUN, ST_FILL, ST_WAIT, ST_SWEEP, ST_SCAN, ST_OUT} st_t;

  // Config
  logic [HW_W-1:0]  hw_reg_r;
  logic [DIM_W-1:0] w_reg_r, h_reg_r;
  logic [HWW-1:0]   hw;
  logic [PW-1:0]    w, h;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_reg_r <= HW_W'(1);
      w_reg_r  <= DIM_W'(640);
      h_reg_r  <= DIM_W'(480);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_HALF_WINDOW:  hw_reg_r <= cfg_data[HW_W-1:0];
        CFG_IMAGE_WIDTH:  w_reg_r  <= cfg_data;
        CFG_IMAGE_HEIGHT: h_reg_r  <= cfg_data;
        default: ;
      endcase
    end
  end
  always_comb begin
    hw = (32'(hw_reg_r) > MAX_HALF_WINDOW) ? HWW'(MAX_HALF_WINDOW) : HWW'(hw_reg_r);
    if (w_reg_r == '0) w = PW'(1);
    else if (32'(w_reg_r) > MAX_WIDTH) w = PW'(MAX_WIDTH);
    else w = PW'(w_reg_r);
    if (h_reg_r == '0) h = PW'(1);
    else if (32'(h_reg_r) > MAX_HEIGHT) h = PW'(MAX_HEIGHT);
    else h = PW'(h_reg_r);
  end
  logic cfg_hit;
  assign cfg_hit = cfg_we && (cfg_idx == CFG_HALF_WINDOW || cfg_idx == CFG_IMAGE_WIDTH
                              || cfg_idx == CFG_IMAGE_HEIGHT);

  // Lag = hw*w + hw (hw is only HWW bits wide)
  logic [LAG_W-1:0] lag;
  assign lag = LAG_W'(hw) * LAG_W'(w) + LAG_W'(hw);

  // Positions
  logic [PW-1:0] in_row_r, in_col_r, out_row_r, out_col_r;
  logic [RW-1:0] in_slot_r, out_slot_r;
  logic [LAG_W-1:0] lag_cnt_r;
  st_t st_r;
  logic ov_r, olast_r;
  logic [PIX_W-1:0] odata_r;
  logic brd_pend_r, brd_last_r;

  logic acc, is_pix, input_done, emit;
  assign input_done = in_row_r >= h;
  // Hold requests while a border copy is on its way to the result register
  assign in_tready = (st_r == ST_RUN) && !brd_pend_r && (!ov_r || out_tready);
  assign acc = in_tvalid && in_tready;
  assign is_pix = in_tuser == CMD_PIXEL;
  assign emit = acc && (is_pix ? (!input_done && lag_cnt_r >= lag)
                               : (input_done && lag_cnt_r != '0));

  // Line memory
  logic [PIX_W-1:0] mem [DEPTH];
  logic [AW-1:0] rd_addr;
  logic [PIX_W-1:0] rd_q;
  logic wr_en;
  assign wr_en = acc && is_pix && !input_done;
  always_ff @(posedge clk) begin
    if (wr_en) mem[AW'(in_slot_r) * AW'(MAX_WIDTH) + AW'(in_col_r[CW-1:0])] <= in_tdata;
    rd_q <= mem[rd_addr];
  end

  // Position of the output being emitted
  logic inner;
  assign inner = out_row_r >= PW'(hw) && out_row_r + PW'(hw) < h
              && out_col_r >= PW'(hw) && out_col_r + PW'(hw) < w;

  // Window fill walk
  logic [RW-1:0] fr_r, fslot_r, fc_r, slot0;
  logic [PW-1:0] fcol_r;
  logic [IW:0]   fidx_r, n_r, lidx_r, sidx_r;
  logic          last_hold_r;
  logic [RW-1:0] side;
  assign side = RW'(2 * hw + 1);
  assign slot0 = (out_slot_r >= RW'(hw)) ? out_slot_r - RW'(hw)
                                         : out_slot_r + RW'(ROWS) - RW'(hw);

  always_comb begin
    if (st_r == ST_FILL) rd_addr = AW'(fslot_r) * AW'(MAX_WIDTH) + AW'(fcol_r[CW-1:0]);
    else rd_addr = AW'(out_slot_r) * AW'(MAX_WIDTH) + AW'(out_col_r[CW-1:0]);
  end

  // Rank cell row
  logic [NCELL-1:0] load;
  logic [PIX_W-1:0] vals [NCELL];
  logic [CNT_W-1:0] lts [NCELL], les [NCELL];
  logic [PIX_W-1:0] cmp_val;
  logic cmp_en, load_vld_r;
  logic [IW:0] load_idx_r;
  assign cmp_en = st_r == ST_SWEEP;
  assign cmp_val = vals[sidx_r[IW-1:0]];
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    assign load[g] = load_vld_r && load_idx_r == (IW+1)'(g);
    wmf_rank_cell #(.CNT_W(CNT_W)) u_cell (
      .clk, .load(load[g]), .load_val(rd_q), .cmp_en(cmp_en && sidx_r < n_r),
      .cmp_val, .val(vals[g]), .lt(lts[g]), .le(les[g]));
  end

  // Border path: memory read registered, then output
  rank_ctl_t ctl;
  assign ctl = '{vld: brd_pend_r, border: 1'b1, last: brd_last_r, copy: rd_q};

  logic [PW-1:0] nxt_col, nxt_row;
  logic nxt_last;
  always_comb begin
    nxt_col = out_col_r + PW'(1);
    nxt_row = out_row_r;
    if (nxt_col >= w) begin
      nxt_col = '0;
      nxt_row = out_row_r + PW'(1);
    end
    nxt_last = nxt_row >= h;
  end

  logic [CNT_W-1:0] mid;
  assign mid = CNT_W'(n_r >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      in_row_r <= '0; in_col_r <= '0; out_row_r <= '0; out_col_r <= '0;
      in_slot_r <= '0; out_slot_r <= '0; lag_cnt_r <= '0;
      st_r <= ST_RUN; ov_r <= 1'b0; brd_pend_r <= 1'b0; load_vld_r <= 1'b0;
    end else begin
      if (ov_r && out_tready) ov_r <= 1'b0;
      load_vld_r <= 1'b0;
      brd_pend_r <= 1'b0;
      // Present border copy
      if (ctl.vld) begin
        ov_r <= 1'b1;
        odata_r <= ctl.copy;
        olast_r <= ctl.last;
      end
      unique case (st_r)
        ST_RUN: begin
          if (wr_en) begin
            if (in_col_r + PW'(1) >= w) begin
              in_col_r <= '0;
              in_row_r <= in_row_r + PW'(1);
              in_slot_r <= (in_slot_r == RW'(ROWS - 1)) ? '0 : in_slot_r + RW'(1);
            end else in_col_r <= in_col_r + PW'(1);
          end
          if (acc) begin
            if (is_pix && !input_done && !emit) lag_cnt_r <= lag_cnt_r + LAG_W'(1);
            if (!is_pix && emit) lag_cnt_r <= lag_cnt_r - LAG_W'(1);
          end
          if (emit) begin
            last_hold_r <= nxt_last;
            if (inner) begin
              st_r <= ST_FILL;
              fslot_r <= slot0; fr_r <= '0; fc_r <= '0;
              fcol_r <= out_col_r - PW'(hw);
              fidx_r <= '0;
              n_r <= (IW+1)'(side) * (IW+1)'(side);
            end else begin
              brd_pend_r <= 1'b1;
              brd_last_r <= nxt_last;
            end
            // Advance output position
            if (nxt_last) begin
              in_row_r <= '0; in_col_r <= '0; out_row_r <= '0; out_col_r <= '0;
              in_slot_r <= '0; out_slot_r <= '0; lag_cnt_r <= '0;
            end else begin
              out_col_r <= nxt_col;
              out_row_r <= nxt_row;
              if (nxt_row != out_row_r)
                out_slot_r <= (out_slot_r == RW'(ROWS - 1)) ? '0 : out_slot_r + RW'(1);
            end
          end
        end
        ST_FILL: begin
          // Stream window pixels into the cells
          load_vld_r <= 1'b1;
          load_idx_r <= fidx_r;
          fidx_r <= fidx_r + (IW+1)'(1);
          if (fc_r == side - RW'(1)) begin
            fc_r <= '0;
            fcol_r <= fcol_r - PW'(side - RW'(1));
            fslot_r <= (fslot_r == RW'(ROWS - 1)) ? '0 : fslot_r + RW'(1);
            if (fr_r == side - RW'(1)) st_r <= ST_WAIT;
            fr_r <= fr_r + RW'(1);
          end else begin
            fc_r <= fc_r + RW'(1);
            fcol_r <= fcol_r + PW'(1);
          end
        end
        ST_WAIT: begin
          st_r <= ST_SWEEP;
          sidx_r <= '0;
        end
        ST_SWEEP: begin
          sidx_r <= sidx_r + (IW+1)'(1);
          if (sidx_r + (IW+1)'(1) == n_r) begin
            st_r <= ST_SCAN;
            lidx_r <= '0;
          end
        end
        ST_SCAN: begin
          // First cell whose rank span covers the middle, else cell 0
          if (lts[lidx_r[IW-1:0]] <= mid && mid < les[lidx_r[IW-1:0]]) begin
            odata_r <= vals[lidx_r[IW-1:0]];
            st_r <= ST_OUT;
          end else if (lidx_r + (IW+1)'(1) == n_r) begin
            odata_r <= vals[0];
            st_r <= ST_OUT;
          end else lidx_r <= lidx_r + (IW+1)'(1);
        end
        ST_OUT: begin
          if (!ov_r || out_tready) begin
            ov_r <= 1'b1;
            olast_r <= last_hold_r;
            st_r <= ST_RUN;
          end
        end
        default: st_r <= ST_RUN;
      endcase
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = odata_r;
  assign out_tlast = olast_r;
endmodule

// ----- hdl/wmf_checker.sv -----
module wmf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [7:0] out_tdata,
  input logic out_tlast
);
  // A stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");
  // Result valid is always known
  a_nodata: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(out_tvalid))
    else $error("unknown result valid");
  // No result is pending right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result after reset");
  // Requests are refused while a result is stalled
  a_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && out_tvalid |-> out_tready)
    else $error("request taken while result stalled");
  // A refused request stays offered
  a_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid)
    else $error("request withdrawn before acceptance");
endmodule

bind window_median_filter wmf_checker u_wmf_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tlast);
